// File: sv/wpr_pkg.sv
`timescale 1ns / 1ps

package wpr_pkg;

    localparam int FRAME_W  = 40;
    localparam int SAMPLE_W = 16;
    localparam int CMD_W    = 2;
    localparam int BUCKET_W = 11;
    localparam int CHCNT_W  = 4;
    localparam int WANT_W   = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [FRAME_W-1:0] MAX_FRAME = {FRAME_W{1'b1}};

    // command codes carried in the cmd field
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_READ   = 2'd2
    } wpr_cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_FRAMES   = 2'd0,
        CFG_CHANNEL_COUNT  = 2'd1,
        CFG_WANTED_BUCKETS = 2'd2
    } wpr_cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [BUCKET_W-1:0]        out_bucket;
    } wpr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] peak_min;
        logic signed [SAMPLE_W-1:0] peak_max;
        logic [FRAME_W-1:0]         span_frames;
    } wpr_out_t;

    typedef struct packed {
        logic [FRAME_W-1:0] total_frames;
        logic [CHCNT_W-1:0] channel_count;
        logic [WANT_W-1:0]  wanted_buckets;
    } wpr_cfg_t;

    // one base bucket entry in the bucket memory
    typedef struct packed {
        logic                       mark;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
    } wpr_word_t;

    // back end status seen by the front end and the config port
    typedef struct packed {
        logic idle;
        logic wiping;
    } wpr_bstat_t;

    typedef enum logic {
        ARITH_MUL = 1'b0,
        ARITH_DIV = 1'b1
    } wpr_arith_op_t;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_SMUL,
        ST_SDIV,
        ST_FETCH,
        ST_UPD,
        ST_RMUL,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_MRG
    } wpr_state_t;

endpackage

// File: sv/wpr_ram.sv
`timescale 1ns / 1ps

module wpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output logic [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/wpr_front.sv
`timescale 1ns / 1ps

module wpr_front
    import wpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  wpr_in_t    item,
    input  wpr_bstat_t bstat,
    output logic       q_valid,
    output wpr_in_t    q_item,
    input  logic       q_pop
);
    wpr_in_t    ent_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    logic       push;

    // accept while the queue has room and no clearing pass runs
    assign busy    = (cnt_reg == 2'd2) || bstat.wiping;
    assign accept  = start && !busy;
    // unused command code is dropped here
    assign push    = accept && (item.cmd inside {CMD_CLEAR, CMD_SAMPLE, CMD_READ});
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = !wr_reg;
        end
        if (q_pop && q_valid)
        begin
            rd_next = !rd_reg;
        end
        case ({push, q_pop && q_valid})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= item;
        end
    end

endmodule

// File: sv/wpr_arith.sv
`timescale 1ns / 1ps

module wpr_arith
    import wpr_pkg::*;
#(
    parameter int NW = 52,
    parameter int DW = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  wpr_arith_op_t op,
    input  logic [NW-1:0] opa,
    input  logic [DW-1:0] opb,
    output logic          done,
    output logic [NW-1:0] res
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    wpr_arith_op_t op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] acc_reg, acc_next;
    logic [NW-1:0] x_reg, x_next;
    logic [DW-1:0] y_reg, y_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW:0]   rem_sh;
    logic          ge;

    assign done = done_reg;
    assign res  = acc_reg;

    // shift-add multiply with early out, restoring divide one bit a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg[DW-1:0], x_reg[NW-1]};
        ge        = (rem_sh >= {1'b0, y_reg});
        if (go)
        begin
            busy_next = 1'b1;
            op_next   = op;
            cnt_next  = '0;
            acc_next  = '0;
            x_next    = opa;
            y_next    = opb;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ARITH_MUL:
                begin
                    if (y_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (y_reg[0])
                        begin
                            acc_next = acc_reg + x_reg;
                        end
                        x_next = {x_reg[NW-2:0], 1'b0};
                        y_next = {1'b0, y_reg[DW-1:1]};
                    end
                end
                ARITH_DIV:
                begin
                    rem_next = ge ? (rem_sh - {1'b0, y_reg}) : rem_sh;
                    acc_next = {acc_reg[NW-2:0], ge};
                    x_next   = {x_reg[NW-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(NW - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
    end

endmodule

// File: sv/wpr_back.sv
`timescale 1ns / 1ps

module wpr_back
    import wpr_pkg::*;
#(
    parameter int BASE_BUCKETS = 2048,
    parameter int MAX_CHANNELS = 8,
    localparam int AW = (BASE_BUCKETS > 1) ? $clog2(BASE_BUCKETS) : 1,
    localparam int BW = $clog2(BASE_BUCKETS + 1),
    localparam int NW = FRAME_W + BW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  wpr_cfg_t      cfg,
    output wpr_bstat_t    bstat,
    input  logic          q_valid,
    input  wpr_in_t       q_item,
    output logic          q_pop,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output wpr_word_t     ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  wpr_word_t     ram_rdata,
    output logic          ar_go,
    output wpr_arith_op_t ar_op,
    output logic [NW-1:0] ar_a,
    output logic [FRAME_W-1:0] ar_b,
    input  logic          ar_done,
    input  logic [NW-1:0] ar_res,
    output logic          result_strobe,
    output wpr_out_t      result
);
    localparam int CCW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WX  = (BW > WANT_W) ? BW : WANT_W;

    wpr_state_t state_reg, state_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [CCW-1:0]     ch_reg, ch_next;
    logic [AW-1:0]      wipe_reg, wipe_next;
    logic [AW-1:0]      bkt_reg, bkt_next;
    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [NW-1:0]      prod_reg, prod_next;
    logic [BW-1:0]      beg_reg, beg_next;
    logic [BW-1:0]      end_reg, end_next;
    logic [FRAME_W-1:0] span_reg, span_next;
    logic [BW-1:0]      j_reg, j_next;
    logic               pend_reg, pend_next;
    logic               first_reg, first_next;
    logic signed [SAMPLE_W-1:0] mn_reg, mn_next;
    logic signed [SAMPLE_W-1:0] mx_reg, mx_next;
    logic               res_stb_reg, res_stb_next;
    wpr_out_t           res_reg, res_next;

    logic [FRAME_W-1:0] t_eff;
    logic [BW-1:0]      base;
    logic [BW-1:0]      base_m1;
    logic [7:0]         ch_eff;
    logic [7:0]         ch_inc;
    logic [WANT_W-1:0]  wq;
    logic [WANT_W-1:0]  w_eff;
    logic [WANT_W-1:0]  kk;
    logic [BW-1:0]      e_q;
    logic signed [SAMPLE_W-1:0] lo_v, hi_v;

    // effective configuration values
    always_comb
    begin
        t_eff   = (cfg.total_frames == '0) ? FRAME_W'(1) : cfg.total_frames;
        base    = (t_eff < FRAME_W'(BASE_BUCKETS)) ? t_eff[BW-1:0] : BW'(BASE_BUCKETS);
        base_m1 = base - BW'(1);
        if (cfg.channel_count == '0)
        begin
            ch_eff = 8'd1;
        end
        else if (8'(cfg.channel_count) > 8'(MAX_CHANNELS))
        begin
            ch_eff = 8'(MAX_CHANNELS);
        end
        else
        begin
            ch_eff = 8'(cfg.channel_count);
        end
        ch_inc = 8'(ch_reg) + 8'd1;
        wq     = (cfg.wanted_buckets == '0) ? WANT_W'(1) : cfg.wanted_buckets;
        w_eff  = (WX'(wq) > WX'(base)) ? WANT_W'(base) : wq;
        kk     = ({1'b0, q_item.out_bucket} >= w_eff) ? (w_eff - WANT_W'(1))
                                                     : {1'b0, q_item.out_bucket};
    end

    assign bstat.idle    = (state_reg == ST_IDLE);
    assign bstat.wiping  = (state_reg == ST_WIPE);
    assign result_strobe = res_stb_reg;
    assign result        = res_reg;

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next   = state_reg;
        frame_next   = frame_reg;
        ch_next      = ch_reg;
        wipe_next    = wipe_reg;
        bkt_next     = bkt_reg;
        smp_next     = smp_reg;
        prod_next    = prod_reg;
        beg_next     = beg_reg;
        end_next     = end_reg;
        span_next    = span_reg;
        j_next       = j_reg;
        pend_next    = pend_reg;
        first_next   = first_reg;
        mn_next      = mn_reg;
        mx_next      = mx_reg;
        res_stb_next = 1'b0;
        res_next     = res_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = bkt_reg;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = bkt_reg;
        ar_go        = 1'b0;
        ar_op        = ARITH_DIV;
        ar_a         = '0;
        ar_b         = FRAME_W'(w_eff);
        e_q          = ar_res[BW-1:0];
        lo_v         = ram_rdata.mark ? ram_rdata.lo : '0;
        hi_v         = ram_rdata.mark ? ram_rdata.hi : '0;

        case (state_reg)
            // clearing pass over the fill marks
            ST_WIPE:
            begin
                ram_we    = 1'b1;
                ram_waddr = wipe_reg;
                wipe_next = wipe_reg + 1'b1;
                if (wipe_reg == AW'(BASE_BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.cmd)
                        CMD_CLEAR:
                        begin
                            frame_next = '0;
                            ch_next    = '0;
                            wipe_next  = '0;
                            state_next = ST_WIPE;
                        end
                        CMD_SAMPLE:
                        begin
                            smp_next = q_item.sample_value;
                            if (frame_reg >= t_eff)
                            begin
                                bkt_next   = AW'(base_m1);
                                state_next = ST_FETCH;
                            end
                            else
                            begin
                                ar_go      = 1'b1;
                                ar_op      = ARITH_MUL;
                                ar_a       = NW'(frame_reg);
                                ar_b       = FRAME_W'(base);
                                state_next = ST_SMUL;
                            end
                        end
                        CMD_READ:
                        begin
                            ar_go      = 1'b1;
                            ar_op      = ARITH_MUL;
                            ar_a       = NW'(kk);
                            ar_b       = FRAME_W'(base);
                            state_next = ST_RMUL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            // bucket index = frame * base / total
            ST_SMUL:
            begin
                if (ar_done)
                begin
                    ar_go      = 1'b1;
                    ar_op      = ARITH_DIV;
                    ar_a       = ar_res;
                    ar_b       = t_eff;
                    state_next = ST_SDIV;
                end
            end
            ST_SDIV:
            begin
                if (ar_done)
                begin
                    bkt_next   = (ar_res > NW'(base_m1)) ? AW'(base_m1) : AW'(ar_res);
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                ram_re     = 1'b1;
                ram_raddr  = bkt_reg;
                state_next = ST_UPD;
            end
            // read-modify-write of the bucket, then advance the counters
            ST_UPD:
            begin
                ram_we         = 1'b1;
                ram_waddr      = bkt_reg;
                ram_wdata.mark = 1'b1;
                if (!ram_rdata.mark)
                begin
                    ram_wdata.lo = smp_reg;
                    ram_wdata.hi = smp_reg;
                end
                else
                begin
                    ram_wdata.lo = (smp_reg < ram_rdata.lo) ? smp_reg : ram_rdata.lo;
                    ram_wdata.hi = (smp_reg > ram_rdata.hi) ? smp_reg : ram_rdata.hi;
                end
                if (ch_inc >= ch_eff)
                begin
                    ch_next = '0;
                    if (frame_reg != MAX_FRAME)
                    begin
                        frame_next = frame_reg + 1'b1;
                    end
                end
                else
                begin
                    ch_next = CCW'(ch_inc);
                end
                state_next = ST_IDLE;
            end
            // range bounds and span for a read request
            ST_RMUL:
            begin
                if (ar_done)
                begin
                    prod_next  = ar_res;
                    ar_go      = 1'b1;
                    ar_a       = ar_res;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                if (ar_done)
                begin
                    beg_next   = e_q;
                    ar_go      = 1'b1;
                    ar_a       = prod_reg + NW'(base);
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                if (ar_done)
                begin
                    end_next   = (e_q <= beg_reg) ? (beg_reg + 1'b1) : e_q;
                    ar_go      = 1'b1;
                    ar_a       = NW'(t_eff) + NW'(w_eff) - NW'(1);
                    state_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                if (ar_done)
                begin
                    span_next  = ar_res[FRAME_W-1:0];
                    j_next     = beg_reg;
                    pend_next  = 1'b0;
                    first_next = 1'b1;
                    state_next = ST_MRG;
                end
            end
            // stream the base buckets through the min/max fold
            ST_MRG:
            begin
                if (pend_reg)
                begin
                    if (first_reg)
                    begin
                        mn_next    = lo_v;
                        mx_next    = hi_v;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        mn_next = (lo_v < mn_reg) ? lo_v : mn_reg;
                        mx_next = (hi_v > mx_reg) ? hi_v : mx_reg;
                    end
                end
                if (j_reg < end_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(j_reg);
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_stb_next         = 1'b1;
                        res_next.peak_min    = mn_reg;
                        res_next.peak_max    = mx_reg;
                        res_next.span_frames = span_reg;
                        state_next           = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_WIPE;
            frame_reg   <= '0;
            ch_reg      <= '0;
            wipe_reg    <= '0;
            pend_reg    <= 1'b0;
            res_stb_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            frame_reg   <= frame_next;
            ch_reg      <= ch_next;
            wipe_reg    <= wipe_next;
            pend_reg    <= pend_next;
            res_stb_reg <= res_stb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bkt_reg   <= bkt_next;
        smp_reg   <= smp_next;
        prod_reg  <= prod_next;
        beg_reg   <= beg_next;
        end_reg   <= end_next;
        span_reg  <= span_next;
        j_reg     <= j_next;
        first_reg <= first_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        res_reg   <= res_next;
    end

`ifndef SYNTH
    // a result only leaves at the end of a merge
    a_res_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
        res_stb_reg |-> $past(state_reg == ST_MRG))
        else $error("result outside merge");

    // no request is taken during the clearing pass
    a_no_pop_wipe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WIPE) |-> !q_pop)
        else $error("pop during clearing pass");

    // a bucket update always follows its fetch
    a_upd_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |=> (state_reg == ST_UPD))
        else $error("fetch not followed by update");

    // merge range is never empty
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MRG) |-> (end_reg > beg_reg))
        else $error("empty merge range");
`endif

endmodule

// File: sv/waveform_minmax_peak_reducer_unit.sv
`timescale 1ns / 1ps

// Min/max waveform decimation. Each request is taken when start is high and
// busy low; cmd clear restarts the frame count, sample folds one interleaved
// Q1.15 sample into its base bucket, read returns the merged min/max of one
// output bucket plus the frames it spans, shown for a single cycle on
// result_strobe (no backpressure). A two-entry queue sits between request
// intake and the sequencer. Cost per request is set by the shared one-bit-
// per-cycle multiply/divide unit: a sample runs a multiply and a divide for
// its bucket index (both skipped once the frame is past the stated length);
// a read runs a multiply and three divides, then streams its base buckets
// through the min/max merge; a clear runs a clearing pass over the fill
// marks, as does reset, and busy stays high during that pass. Configuration
// is taken only when the block is idle and the queue is empty.
module waveform_minmax_peak_reducer_unit
    import wpr_pkg::*;
#(
    parameter int BASE_BUCKETS = 2048,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  wpr_in_t              item,
    output logic                 result_strobe,
    output wpr_out_t             result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]   cfg_data
);
    localparam int AW = (BASE_BUCKETS > 1) ? $clog2(BASE_BUCKETS) : 1;
    localparam int BW = $clog2(BASE_BUCKETS + 1);
    localparam int NW = FRAME_W + BW;

    wpr_cfg_t      cfg_reg, cfg_next;
    wpr_bstat_t    bstat;
    logic          q_valid;
    wpr_in_t       q_item;
    logic          q_pop;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    wpr_word_t     ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    wpr_word_t     ram_rdata;
    logic          ar_go;
    wpr_arith_op_t ar_op;
    logic [NW-1:0] ar_a;
    logic [FRAME_W-1:0] ar_b;
    logic          ar_done;
    logic [NW-1:0] ar_res;

    // config registers, written only while nothing is in flight
    assign cfg_ready = bstat.idle && !q_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOTAL_FRAMES:   cfg_next.total_frames   = cfg_data;
                CFG_CHANNEL_COUNT:  cfg_next.channel_count  = cfg_data[CHCNT_W-1:0];
                CFG_WANTED_BUCKETS: cfg_next.wanted_buckets = cfg_data[WANT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_frames   <= FRAME_W'(1);
            cfg_reg.channel_count  <= CHCNT_W'(2);
            cfg_reg.wanted_buckets <= WANT_W'(2048);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wpr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .bstat   (bstat),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    wpr_arith #(
        .NW (NW),
        .DW (FRAME_W)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (ar_go),
        .op    (ar_op),
        .opa   (ar_a),
        .opb   (ar_b),
        .done  (ar_done),
        .res   (ar_res)
    );

    wpr_ram #(
        .WIDTH ($bits(wpr_word_t)),
        .DEPTH (BASE_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wpr_back #(
        .BASE_BUCKETS (BASE_BUCKETS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .bstat         (bstat),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .ar_go         (ar_go),
        .ar_op         (ar_op),
        .ar_a          (ar_a),
        .ar_b          (ar_b),
        .ar_done       (ar_done),
        .ar_res        (ar_res),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// File: verif/tb_waveform_minmax_peak_reducer_unit.sv
`timescale 1ns / 1ps

module tb_waveform_minmax_peak_reducer_unit;
    import wpr_pkg::*;

    localparam int NBUCKET = 2048;
    localparam int MAXCH = 8;
    localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    // a clear or a wide merge may still run after the last read result
    localparam int DRAIN_CYCLES = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    wpr_in_t item = '0;
    logic result_strobe;
    wpr_out_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FRAME_W-1:0] cfg_data = '0;

    always #2 clk = ~clk;

    waveform_minmax_peak_reducer_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow copy of the bucket state and registers
    longint unsigned sh_total, sh_chans, sh_want, sh_frame, sh_chan;
    logic signed [SAMPLE_W-1:0] sh_lo [NBUCKET];
    logic signed [SAMPLE_W-1:0] sh_hi [NBUCKET];
    bit sh_filled [NBUCKET];

    wpr_out_t peak_q[$];
    int err_count = 0;
    int n_samples = 0, n_reads = 0, n_clears = 0, n_cfg = 0, n_checked = 0;
    int idle_pct = 0;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic longint unsigned eff_total();
        return (sh_total == 0) ? 1 : sh_total;
    endfunction

    function automatic longint unsigned base_count();
        longint unsigned t;
        t = eff_total();
        return (t < NBUCKET) ? t : NBUCKET;
    endfunction

    function automatic void fold_sample(input logic signed [SAMPLE_W-1:0] s);
        longint unsigned base, b, ch;
        base = base_count();
        b = sh_frame * base / eff_total();
        if (b > base - 1) b = base - 1;
        if (!sh_filled[b]) begin
            sh_lo[b] = s;
            sh_hi[b] = s;
            sh_filled[b] = 1'b1;
        end
        else begin
            if (s < sh_lo[b]) sh_lo[b] = s;
            if (s > sh_hi[b]) sh_hi[b] = s;
        end
        ch = (sh_chans == 0) ? 1 : ((sh_chans > MAXCH) ? MAXCH : sh_chans);
        sh_chan++;
        if (sh_chan >= ch) begin
            sh_chan = 0;
            if (sh_frame < MASK40) sh_frame++;
        end
    endfunction

    function automatic wpr_out_t merge_bucket(input logic [BUCKET_W-1:0] ob);
        longint unsigned base, w, k, b0, b1;
        logic signed [SAMPLE_W-1:0] lo, hi, mn, mx;
        wpr_out_t r;
        base = base_count();
        w = (sh_want < 1) ? 1 : sh_want;
        if (w > base) w = base;
        k = ob;
        if (k > w - 1) k = w - 1;
        b0 = k * base / w;
        b1 = (k + 1) * base / w;
        if (b1 < b0 + 1) b1 = b0 + 1;
        mn = 0;
        mx = 0;
        for (longint unsigned j = b0; j < b1 && j < NBUCKET; j++) begin
            lo = sh_filled[j] ? sh_lo[j] : 16'sd0;
            hi = sh_filled[j] ? sh_hi[j] : 16'sd0;
            if (j == b0) begin
                mn = lo;
                mx = hi;
            end
            else begin
                if (lo < mn) mn = lo;
                if (hi > mx) mx = hi;
            end
        end
        r.peak_min = mn;
        r.peak_max = mx;
        r.span_frames = FRAME_W'(((eff_total() + w - 1) / w) & MASK40);
        if (r.span_frames == 0) r.span_frames = 1;
        return r;
    endfunction

    // update shadow state for one accepted request; returns 1 when a result is due
    function automatic bit predict_request(input wpr_in_t rq, output wpr_out_t r);
        r = '0;
        case (rq.cmd)
            CMD_CLEAR: begin
                sh_frame = 0;
                sh_chan = 0;
                foreach (sh_filled[i]) sh_filled[i] = 1'b0;
                n_clears++;
            end
            CMD_SAMPLE: begin
                fold_sample(rq.sample_value);
                n_samples++;
            end
            CMD_READ: begin
                r = merge_bucket(rq.out_bucket);
                n_reads++;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // drive one request; optional fixed expectation overrides the predictor
    task automatic send_request(input wpr_in_t rq, input bit fixed, input wpr_out_t fexp);
        wpr_out_t r;
        @(negedge clk);
        start = 1'b1;
        item = rq;
        do @(posedge clk); while (busy);
        if (predict_request(rq, r)) peak_q.push_back(fixed ? fexp : r);
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(99) < idle_pct) begin
            n = $urandom_range(1, 6);
            @(negedge clk);
            start = 1'b0;
            item = '0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (peak_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input wpr_cfg_idx_t idx, input longint unsigned val);
        logic [FRAME_W-1:0] d;
        d = FRAME_W'({$urandom, $urandom});
        case (idx)
            CFG_TOTAL_FRAMES:  d = val[FRAME_W-1:0];
            CFG_CHANNEL_COUNT: d[CHCNT_W-1:0] = val[CHCNT_W-1:0];
            default:           d[WANT_W-1:0] = val[WANT_W-1:0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_TOTAL_FRAMES:  sh_total = d;
            CFG_CHANNEL_COUNT: sh_chans = d[CHCNT_W-1:0];
            default:           sh_want = d[WANT_W-1:0];
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // result check against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && result_strobe) begin
            if (peak_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end
            else begin
                wpr_out_t e;
                e = peak_q.pop_front();
                n_checked++;
                if (result.peak_min !== e.peak_min)
                    report_mismatch($sformatf("peak_min %0d, expected %0d",
                        result.peak_min, e.peak_min));
                if (result.peak_max !== e.peak_max)
                    report_mismatch($sformatf("peak_max %0d, expected %0d",
                        result.peak_max, e.peak_max));
                if (result.span_frames !== e.span_frames)
                    report_mismatch($sformatf("span_frames %0d, expected %0d",
                        result.span_frames, e.span_frames));
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    int stall_cnt = 0;
    always @(posedge clk) begin
        if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    typedef struct {
        wpr_in_t  rq;
        bit       fixed;
        wpr_out_t fexp;
    } dir_row_t;

    function automatic wpr_in_t mk(input logic [CMD_W-1:0] c, input logic [15:0] s,
                                   input logic [BUCKET_W-1:0] b);
        wpr_in_t r;
        r.cmd = c;
        r.sample_value = s;
        r.out_bucket = b;
        return r;
    endfunction

    function automatic wpr_out_t mko(input logic [15:0] mn, input logic [15:0] mx,
                                     input longint unsigned sp);
        wpr_out_t r;
        r.peak_min = mn;
        r.peak_max = mx;
        r.span_frames = sp[FRAME_W-1:0];
        return r;
    endfunction

    // phase settings: total_frames, channel_count, wanted_buckets
    longint unsigned ph_tot [8] = '{0, 37, MASK40, 2048, 5000, 100, 600, 1};
    longint unsigned ph_ch  [8] = '{0, 3, 15, 1, 8, 2, 4, 9};
    longint unsigned ph_w   [8] = '{0, 5, 4095, 2048, 1, 7, 33, 3};

    initial begin
        dir_row_t dir_rows[$];
        wpr_in_t rq;
        int pick;
        longint unsigned t;

        sh_total = 1;
        sh_chans = 2;
        sh_want = 2048;
        sh_frame = 0;
        sh_chan = 0;
        foreach (sh_filled[i]) begin
            sh_filled[i] = 1'b0;
            sh_lo[i] = '0;
            sh_hi[i] = '0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset settings (one base bucket)
        dir_rows.push_back('{mk(CMD_READ, 16'h0, 11'd0), 1, mko(16'h0, 16'h0, 1)});
        dir_rows.push_back('{mk(CMD_SAMPLE, 16'h7FFF, 11'h7FF), 0, '0});
        dir_rows.push_back('{mk(CMD_SAMPLE, 16'h8000, 11'h0), 0, '0});
        dir_rows.push_back('{mk(CMD_READ, 16'hFFFF, 11'd0), 1, mko(16'h8000, 16'h7FFF, 1)});
        dir_rows.push_back('{mk(CMD_READ, 16'h0, 11'h7FF), 1, mko(16'h8000, 16'h7FFF, 1)});
        dir_rows.push_back('{mk(CMD_UNUSED, 16'h1234, 11'h3), 0, '0});
        dir_rows.push_back('{mk(CMD_READ, 16'h0, 11'd1), 1, mko(16'h8000, 16'h7FFF, 1)});
        dir_rows.push_back('{mk(CMD_CLEAR, 16'hFFFF, 11'h7FF), 0, '0});
        dir_rows.push_back('{mk(CMD_READ, 16'h0, 11'd5), 1, mko(16'h0, 16'h0, 1)});
        dir_rows.push_back('{mk(CMD_SAMPLE, 16'h5555, 11'h2AA), 0, '0});
        dir_rows.push_back('{mk(CMD_SAMPLE, 16'hAAAA, 11'h555), 0, '0});
        dir_rows.push_back('{mk(CMD_SAMPLE, 16'h0001, 11'h0), 0, '0});
        dir_rows.push_back('{mk(CMD_READ, 16'h0, 11'd0), 0, '0});
        foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].fixed,
                                           dir_rows[i].fexp);
        drain();

        // fixed setting phases, then random settings
        for (int ph = 0; ph < 14; ph++) begin
            idle_pct = (ph < 5) ? 14 : ((ph < 10) ? 54 : 0);
            if (ph < 8) begin
                write_cfg(CFG_TOTAL_FRAMES, ph_tot[ph]);
                write_cfg(CFG_CHANNEL_COUNT, ph_ch[ph]);
                write_cfg(CFG_WANTED_BUCKETS, ph_w[ph]);
            end
            else begin
                t = ($urandom_range(3) == 0) ? {$urandom, $urandom} & MASK40
                                             : $urandom_range(1, 3000);
                write_cfg(CFG_TOTAL_FRAMES, t);
                write_cfg(CFG_CHANNEL_COUNT, $urandom_range(0, 15));
                write_cfg(CFG_WANTED_BUCKETS, ($urandom_range(1) == 0)
                          ? $urandom_range(0, 4095) : $urandom_range(1, 64));
            end
            // a stream starts with a clear
            send_request(mk(CMD_CLEAR, 16'($urandom), BUCKET_W'($urandom)), 0, '0);
            for (int n = 0; n < 31; n++) begin
                idle_gap();
                pick = $urandom_range(99);
                rq.sample_value = SAMPLE_W'($urandom);
                rq.out_bucket = ($urandom_range(1) == 0)
                                ? BUCKET_W'($urandom_range(0, 2047))
                                : BUCKET_W'($urandom_range(0, 15));
                if (pick < 72) rq.cmd = CMD_SAMPLE;
                else if (pick < 94) rq.cmd = CMD_READ;
                else if (pick < 97) rq.cmd = CMD_CLEAR;
                else rq.cmd = CMD_UNUSED;
                send_request(rq, 0, '0);
            end
            drain();
        end

        $display("Covered %0d samples, %0d reads (%0d results checked), %0d clears,",
                 n_samples, n_reads, n_checked, n_clears);
        $display("and %0d register writes over 14 setting phases", n_cfg);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: waveform_minmax_peak_reducer_unit.f
sv/wpr_pkg.sv
sv/wpr_ram.sv
sv/wpr_front.sv
sv/wpr_arith.sv
sv/wpr_back.sv
sv/waveform_minmax_peak_reducer_unit.sv
verif/tb_waveform_minmax_peak_reducer_unit.sv
